// File: hdl/ring_clock_face_led_mapper_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ring clock face LED mapper.
// ----------------------------------------------------------------------------
`ifndef RING_CLOCK_FACE_LED_MAPPER_ASSERT_SVH
`define RING_CLOCK_FACE_LED_MAPPER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RCF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rcf assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define RCF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rcf assertion failed");

`endif

// File: hdl/rcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types and constants of the ring clock face LED mapper.
// ----------------------------------------------------------------------------
package rcf_pkg;

   localparam int BCD_W   = 8;
   localparam int LED_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int COLOR_W = 24;
   localparam int CSR_IDX_W = 2;

   localparam logic [LED_W-1:0] LAST_LED = 6'd59;

   localparam logic [COLOR_W-1:0] HOUR_COLOR_RST   = 24'hFF0000;
   localparam logic [COLOR_W-1:0] MINUTE_COLOR_RST = 24'h00FF00;
   localparam logic [COLOR_W-1:0] SECOND_COLOR_RST = 24'h0000FF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOUR_COLOR   = 2'd0,
      CSR_MINUTE_COLOR = 2'd1,
      CSR_SECOND_COLOR = 2'd2
   } csr_idx_type;

   // hand positions on the ring
   typedef struct packed {
      logic [LED_W-1:0] hour;
      logic [LED_W-1:0] minute;
      logic [LED_W-1:0] second;
   } pos_type;

endpackage

// File: hdl/rcf_pos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_pos
// Converts a BCD time into ring LED positions for the three hands.
// ----------------------------------------------------------------------------
module rcf_pos (
   input  logic [rcf_pkg::BCD_W-1:0] hour_bcd,
   input  logic [rcf_pkg::BCD_W-1:0] minute_bcd,
   input  logic [rcf_pkg::BCD_W-1:0] second_bcd,
   output rcf_pkg::pos_type          pos
);
   import rcf_pkg::*;

   // nibbles taken as plain binary, so up to 15*10+15
   function automatic logic [BCD_W-1:0] bcd_bin(input logic [BCD_W-1:0] b);
      logic [BCD_W-1:0] hi;
      hi = {4'b0000, b[7:4]};
      return (hi << 3) + (hi << 1) + {4'b0000, b[3:0]};
   endfunction

   function automatic logic [LED_W-1:0] clamp_pos(input logic [BCD_W-1:0] v);
      return (v > {2'b00, LAST_LED}) ? LAST_LED : v[LED_W-1:0];
   endfunction

   logic [BCD_W-1:0]  hour_bin;
   logic [15:0]       hour_prod;
   logic [3:0]        hour_quo;
   logic [BCD_W-1:0]  hour_q12;
   logic [BCD_W-1:0]  hour_rem;

   // v mod 12 by reciprocal: 171/2048 is exact for v up to 165
   assign hour_bin  = bcd_bin(hour_bcd);
   assign hour_prod = {8'b0, hour_bin} * 16'd171;
   assign hour_quo  = hour_prod[14:11];
   assign hour_q12  = {1'b0, hour_quo, 3'b000} + {2'b00, hour_quo, 2'b00};
   assign hour_rem  = hour_bin - hour_q12;

   assign pos.hour   = {hour_rem[3:0], 2'b00} + {2'b00, hour_rem[3:0]};
   assign pos.minute = clamp_pos(bcd_bin(minute_bcd));
   assign pos.second = clamp_pos(bcd_bin(second_bcd));

endmodule

// File: hdl/ring_clock_face_led_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_clock_face_led_mapper
// Turns BCD time items into LED writes for a 60-LED ring clock face.
//
// req_ channel: one item is a BCD time (hour, minute, second), taken at an
// edge with req_valid high and req_stall low. It lands in an input register,
// then moves into the write sequencer, which updates the hand positions and
// builds a list of two to six LED writes: black to each hand LED that moved,
// the hour and minute hands (one blinking write when they share an LED), and
// the second hand last with rsp_last_write set.
// rsp_ channel: the LED writes of an item, one at a time, from an output
// register; an item passes the input register and the sequencer first.
// The sequencer issues one write per cycle while the output is not stalled;
// the next item waits in the input register and enters as the last write
// of the one before leaves. While rsp_stall is high with a write held, the
// sequencer stops and the held write stays unchanged; req_stall rises once
// the input register is full and the sequencer is busy.
// csr_ channel: colors, ready at all times; write only while idle.
// Reset clears hand positions, blink phase, all valids and restores colors.
// ----------------------------------------------------------------------------
module ring_clock_face_led_mapper (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rcf_pkg::BCD_W-1:0]     req_hour_bcd,
   input  logic [rcf_pkg::BCD_W-1:0]     req_minute_bcd,
   input  logic [rcf_pkg::BCD_W-1:0]     req_second_bcd,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rcf_pkg::LED_W-1:0]     rsp_led_index,
   output logic [rcf_pkg::BYTE_W-1:0]    rsp_red,
   output logic [rcf_pkg::BYTE_W-1:0]    rsp_green,
   output logic [rcf_pkg::BYTE_W-1:0]    rsp_blue,
   output logic                          rsp_last_write,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rcf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rcf_pkg::COLOR_W-1:0]   csr_data
);
   import rcf_pkg::*;
`include "ring_clock_face_led_mapper_assert.svh"

   localparam int NUM_SLOTS = 6;
   localparam int SLOT_OLD_HOUR   = 0;
   localparam int SLOT_OLD_MINUTE = 1;
   localparam int SLOT_OLD_SECOND = 2;
   localparam int SLOT_HAND_A     = 3;
   localparam int SLOT_HAND_B     = 4;
   localparam int SLOT_SECOND     = 5;

   // configuration
   logic [COLOR_W-1:0] hour_color_ff, minute_color_ff, second_color_ff;

   // input register
   logic               in_vld_ff, in_vld_in;
   logic [BCD_W-1:0]   in_hour_ff, in_minute_ff, in_second_ff;

   // hand state and sequencer
   pos_type            pos_new;
   pos_type            cur_ff, cur_in;
   pos_type            old_ff, old_in;
   logic               phase_ff, phase_in;
   logic               hand_a_min_ff, hand_a_min_in;
   logic [NUM_SLOTS-1:0] pend_ff, pend_in, pick, rest, plan;
   logic               shared;

   // output register
   logic               rsp_vld_ff, rsp_vld_in;
   logic [LED_W-1:0]   rsp_led_ff, rsp_led_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic               rsp_last_ff, rsp_last_in;

   logic req_take, out_free, seq_emit, seq_free, a_take;

   rcf_pos u_pos (
      .hour_bcd   (in_hour_ff),
      .minute_bcd (in_minute_ff),
      .second_bcd (in_second_ff),
      .pos        (pos_new)
   );

   assign out_free = !rsp_vld_ff || !rsp_stall;
   assign pick     = pend_ff & (~pend_ff + 6'd1);
   assign rest     = pend_ff & ~pick;
   assign seq_emit = (pend_ff != '0) && out_free;
   assign seq_free = (pend_ff == '0) || (seq_emit && (rest == '0));
   assign a_take   = in_vld_ff && seq_free;
   assign req_stall = in_vld_ff && !a_take;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign shared = (pos_new.hour == pos_new.minute);
   always_comb begin
      plan = '0;
      plan[SLOT_OLD_HOUR]   = (pos_new.hour   != cur_ff.hour);
      plan[SLOT_OLD_MINUTE] = (pos_new.minute != cur_ff.minute);
      plan[SLOT_OLD_SECOND] = (pos_new.second != cur_ff.second);
      plan[SLOT_HAND_A]     = 1'b1;
      plan[SLOT_HAND_B]     = !shared;
      plan[SLOT_SECOND]     = 1'b1;
   end

   always_comb begin
      in_vld_in     = req_take ? 1'b1 : (a_take ? 1'b0 : in_vld_ff);
      cur_in        = cur_ff;
      old_in        = old_ff;
      phase_in      = phase_ff;
      hand_a_min_in = hand_a_min_ff;
      pend_in       = seq_emit ? rest : pend_ff;
      if (a_take) begin
         cur_in        = pos_new;
         old_in        = cur_ff;
         pend_in       = plan;
         hand_a_min_in = shared && phase_ff;
         if (shared) begin
            phase_in = !phase_ff;
         end
      end
   end

   // write selected from the lowest pending slot
   always_comb begin
      rsp_led_in   = cur_ff.second;
      rsp_color_in = second_color_ff;
      rsp_last_in  = 1'b0;
      if (pick[SLOT_OLD_HOUR]) begin
         rsp_led_in   = old_ff.hour;
         rsp_color_in = '0;
      end else if (pick[SLOT_OLD_MINUTE]) begin
         rsp_led_in   = old_ff.minute;
         rsp_color_in = '0;
      end else if (pick[SLOT_OLD_SECOND]) begin
         rsp_led_in   = old_ff.second;
         rsp_color_in = '0;
      end else if (pick[SLOT_HAND_A]) begin
         rsp_led_in   = cur_ff.hour;
         rsp_color_in = hand_a_min_ff ? minute_color_ff : hour_color_ff;
      end else if (pick[SLOT_HAND_B]) begin
         rsp_led_in   = cur_ff.minute;
         rsp_color_in = minute_color_ff;
      end else begin
         rsp_last_in  = 1'b1;
      end
      rsp_vld_in = seq_emit ? 1'b1 : (rsp_vld_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_color_ff   <= HOUR_COLOR_RST;
         minute_color_ff <= MINUTE_COLOR_RST;
         second_color_ff <= SECOND_COLOR_RST;
         in_vld_ff       <= 1'b0;
         cur_ff          <= '0;
         phase_ff        <= 1'b0;
         pend_ff         <= '0;
         rsp_vld_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_HOUR_COLOR:   hour_color_ff   <= csr_data;
               CSR_MINUTE_COLOR: minute_color_ff <= csr_data;
               CSR_SECOND_COLOR: second_color_ff <= csr_data;
               default: ;
            endcase
         end
         in_vld_ff  <= in_vld_in;
         cur_ff     <= cur_in;
         phase_ff   <= phase_in;
         pend_ff    <= pend_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_hour_ff   <= req_hour_bcd;
         in_minute_ff <= req_minute_bcd;
         in_second_ff <= req_second_bcd;
      end
      old_ff        <= old_in;
      hand_a_min_ff <= hand_a_min_in;
      if (seq_emit) begin
         rsp_led_ff   <= rsp_led_in;
         rsp_color_ff <= rsp_color_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_led_index  = rsp_led_ff;
   assign rsp_red        = rsp_color_ff[23:16];
   assign rsp_green      = rsp_color_ff[15:8];
   assign rsp_blue       = rsp_color_ff[7:0];
   assign rsp_last_write = rsp_last_ff;

   `RCF_ASSERT_NEXT(a_plan_ends_with_second, a_take, pend_ff[SLOT_SECOND])
   `RCF_ASSERT_NOW(a_pick_onehot, seq_emit, $onehot(pick))
   `RCF_ASSERT_NOW(a_led_in_range, rsp_vld_ff, rsp_led_ff <= LAST_LED)
   `RCF_ASSERT_NOW(a_idle_seq_takes, in_vld_ff && (pend_ff == '0), !req_stall)

endmodule
